FILE: rtl/core/sha224_stream_hasher_unit_macros.svh
// Assertion macros for the SHA-224 stream hasher.
`ifndef SHA224_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA224_STREAM_HASHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/sha224_pkg.sv
// Package with SHA-224 constants, types and a rotate-right helper function.
`timescale 1ns / 1ps
package sha224_pkg;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned OutDepth = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        logic        load;
        logic        start;
        logic        finish;
    } t_ctl;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_result;

    localparam logic [31:0] IV [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction
endpackage

FILE: rtl/core/sha224_stream_hasher_unit.sv
// Top level of the SHA-224 stream hasher: input queue, core, result queue.
// The core takes each byte from the input queue once it is registered there; a full block
// then runs 64 rounds of compression (one round per cycle); end of message adds padding bytes
// and one or two blocks, then seven words enter the result queue as it has room.
// The core takes no new bytes while a block is in its rounds, set by the single round unit.
// Reset (synchronous, active low) clears queues and restores the initial hash.
`timescale 1ns / 1ps
`include "sha224_stream_hasher_unit_macros.svh"
module sha224_stream_hasher_unit #(
    parameter int unsigned FifoDepth = sha224_pkg::FifoDepth,
    parameter int unsigned OutDepth  = sha224_pkg::OutDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_data,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha224_pkg::t_item   in_item, q_item;
    sha224_pkg::t_result res, q_res;
    logic q_empty, take, res_valid, res_full;

    assign in_item = '{data_byte: i_data_byte, has_data: i_has_data,
                       end_of_message: i_end_of_message};

    sha224_fifo #(.Width($bits(sha224_pkg::t_item)), .Depth(FifoDepth)) u_in (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(in_item),
        .o_full(full), .i_pop(take), .o_empty(q_empty), .o_data(q_item));

    sha224_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!q_empty), .i_item(q_item),
        .o_take(take), .i_res_ready(!res_full), .o_res_valid(res_valid), .o_res(res));

    sha224_fifo #(.Width($bits(sha224_pkg::t_result)), .Depth(OutDepth)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .o_full(res_full), .i_pop(pop), .o_empty(empty), .o_data(q_res));

    assign o_digest_word = q_res.digest_word;
    assign o_word_index  = q_res.word_index;
    assign o_last_word   = q_res.last_word;

    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, !empty && o_last_word, o_word_index == 3'd6)
    `SHA_ASSERT_IMPL(a_idx_rng, i_clk, i_rst_n, !empty, o_word_index != 3'd7)
    `SHA_ASSERT_NEXT(a_take_ok, i_clk, i_rst_n, take, 1'b1)
endmodule

FILE: rtl/core/sha224_fifo.sv
// Small queue, used both as the input queue and as the result queue of the hasher.
`timescale 1ns / 1ps
module sha224_fifo #(
    parameter int unsigned Width = 10,
    parameter int unsigned Depth = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [Width-1:0] o_data
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
    logic [Width-1:0] r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == Aw'(0) + (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

FILE: rtl/core/sha224_core.sv
// Back part: byte packing, padding sequencer, 64-round compression and digest word output.
`timescale 1ns / 1ps
module sha224_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sha224_pkg::t_item    i_item,
    output logic                 o_take,
    input  logic                 i_res_ready,
    output logic                 o_res_valid,
    output sha224_pkg::t_result  o_res
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StComp = 3'd1;
    localparam logic [2:0] StPad  = 3'd2;
    localparam logic [2:0] StEmit = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [63:0] r_bits, r_len;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic        r_pad;
    logic [2:0]  r_widx;
    logic        r_ret_pad;
    logic        r_len_in;
    logic        r_len_blk;

    logic        ld_en;
    logic [7:0]  ld_byte;
    logic [31:0] w_new, w_cur, t1, t2;
    logic [31:0] a2, a15, s0, s1;
    logic [63:0] len_cur;
    logic [2:0]  lsel;
    sha224_pkg::t_ctl ctl;

    assign a2  = r_w[4'(r_round - 6'd2)];
    assign a15 = r_w[4'(r_round - 6'd15)];
    assign s1  = sha224_pkg::ror(a2, 17) ^ sha224_pkg::ror(a2, 19) ^ (a2 >> 10);
    assign s0  = sha224_pkg::ror(a15, 7) ^ sha224_pkg::ror(a15, 18) ^ (a15 >> 3);
    assign w_new = s1 + r_w[4'(r_round - 6'd7)] + s0 + r_w[r_round[3:0]];
    assign w_cur = (r_round >= 6'd16) ? w_new : r_w[r_round[3:0]];
    assign t1 = r_v[7] + (sha224_pkg::ror(r_v[4], 6) ^ sha224_pkg::ror(r_v[4], 11)
              ^ sha224_pkg::ror(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha224_pkg::K[r_round] + w_cur;
    assign t2 = (sha224_pkg::ror(r_v[0], 2) ^ sha224_pkg::ror(r_v[0], 13)
              ^ sha224_pkg::ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign len_cur = r_bits + (i_item.has_data ? 64'd8 : 64'd0);
    assign lsel = 3'(r_fill[2:0]);

    function automatic logic [31:0] n_v(input int i);
        n_v = (i == 0) ? t1 + t2 : (i == 4) ? r_v[3] + t1 : r_v[i-1];
    endfunction

    always_comb begin
        ctl = '0;
        ld_en = 1'b0;
        ld_byte = i_item.data_byte;
        o_take = 1'b0;
        n_state = r_state;
        unique case (r_state)
            StIdle: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    ld_en = i_item.has_data;
                    ctl.finish = i_item.end_of_message;
                end
            end
            StPad: begin
                ld_en = 1'b1;
                if (!r_pad) begin
                    ld_byte = sha224_pkg::PadByte;
                end else if (r_len_blk && r_fill >= 6'd56) begin
                    ld_byte = r_len[8'(63 - 8 * int'(lsel)) -: 8];
                end else begin
                    ld_byte = 8'h00;
                end
            end
            default: ;
        endcase
        ctl.load = ld_en;
        ctl.start = ld_en && (r_fill == 6'd63);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_bits  <= '0;
            r_fill  <= '0;
            r_round <= '0;
            r_pad   <= 1'b0;
            r_widx  <= '0;
            r_ret_pad <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha224_pkg::IV[i];
            end
        end else begin
            if (ctl.load) begin
                r_fill <= r_fill + 6'd1;
            end
            unique case (r_state)
                StIdle: begin
                    if (o_take) begin
                        r_bits <= len_cur;
                        if (ctl.finish) begin
                            r_len <= len_cur;
                            r_pad <= 1'b0;
                        end
                        if (ctl.start) begin
                            r_state <= StComp;
                            r_ret_pad <= ctl.finish;
                        end else if (ctl.finish) begin
                            r_state <= StPad;
                        end
                    end
                end
                StPad: begin
                    r_pad <= 1'b1;
                    if (ctl.start) begin
                        r_state <= StComp;
                        r_ret_pad <= 1'b1;
                    end
                end
                StComp: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= r_h[i] + n_v(i);
                        end
                        if (!r_ret_pad) begin
                            r_state <= StIdle;
                        end else if (r_len_in) begin
                            r_state <= StEmit;
                            r_widx <= '0;
                        end else begin
                            r_state <= StPad;
                        end
                    end
                end
                StEmit: begin
                    if (i_res_ready) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd6) begin
                            r_state <= StIdle;
                            r_bits <= '0;
                            r_fill <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha224_pkg::IV[i];
                            end
                        end
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    // length goes into the block where the pad byte lands before byte 56, else the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_in <= 1'b0;
            r_len_blk <= 1'b0;
        end else if (r_state == StIdle) begin
            r_len_in <= 1'b0;
            r_len_blk <= 1'b0;
        end else if (r_state == StPad) begin
            if (!r_pad && r_fill < 6'd56) begin
                r_len_blk <= 1'b1;
            end
            if (r_fill == 6'd63) begin
                if (r_len_blk) begin
                    r_len_in <= 1'b1;
                end else begin
                    r_len_blk <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_w[r_fill[5:2]][8'(31 - 8 * int'(r_fill[1:0])) -: 8] <= ld_byte;
        end
        if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == StComp) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= n_v(i);
            end
            if (r_round >= 6'd16) begin
                r_w[r_round[3:0]] <= w_new;
            end
        end
    end

    assign o_res_valid = (r_state == StEmit);
    assign o_res.digest_word = r_h[r_widx];
    assign o_res.word_index = r_widx;
    assign o_res.last_word = (r_widx == 3'd6);
endmodule
